@@ hw/rtl/qvr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and widths for the quaternion vector rotation pipeline.
// No dependencies; every other file in this block imports it.
package qvr_pkg;

  // Field widths: Q2.14 quaternion parts and integer vector components
  localparam int QW = 16;
  localparam int VW = 16;
  // First product stage: 16x16 products and the three-term sums of conj(q)*v
  localparam int P1W = QW + VW;
  localparam int TW  = P1W + 1;
  // Second product stage: t*q products and their four-term sums
  localparam int P2W = TW + QW;
  localparam int RW  = P2W + 2;
  // Fraction bits of the final sums (2^14 * 2^14)
  localparam int FRAC_TOTAL = 28;
  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = QW;
  localparam logic signed [QW-1:0] QUAT_W_RESET = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [VW-1:0] rot_x;
    logic signed [VW-1:0] rot_y;
    logic signed [VW-1:0] rot_z;
    logic                 clipped;
  } rot_t;

  // Intermediate quaternion t = conj(q) * (v, 0), scale 2^14
  typedef struct packed {
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
    logic signed [TW-1:0] z;
    logic signed [TW-1:0] w;
  } tquat_t;

  // Unrounded vector part of t * q, scale 2^28
  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [RW-1:0] z;
  } rsum_t;

endpackage

@@ hw/rtl/qvr_conj_mul.sv @@
`timescale 1ns / 1ps
// Two pipeline stages forming t = conj(q) * (v, 0): products, then sums.
// Depends on qvr_pkg.
module qvr_conj_mul
  import qvr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  quat_t  quat,
  input  logic   vec_valid,
  output logic   vec_stall,
  input  vec_t   vec,
  output logic   t_valid,
  input  logic   t_stall,
  output tquat_t t
);

  logic                 prod_valid;
  logic signed [P1W-1:0] prod [12];
  logic                 adv_prod;
  logic                 adv_sum;

  // Advance a stage when it is empty or the next one moves
  assign adv_sum   = !t_valid || !t_stall;
  assign adv_prod  = !prod_valid || adv_sum;
  assign vec_stall = !adv_prod;

  // Stage one: the twelve 16x16 products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv_prod) begin
      prod_valid <= vec_valid;
    end
    if (adv_prod && vec_valid) begin
      prod[0]  <= P1W'($signed(quat.w) * $signed(vec.vec_x));
      prod[1]  <= P1W'($signed(quat.y) * $signed(vec.vec_z));
      prod[2]  <= P1W'($signed(quat.z) * $signed(vec.vec_y));
      prod[3]  <= P1W'($signed(quat.w) * $signed(vec.vec_y));
      prod[4]  <= P1W'($signed(quat.x) * $signed(vec.vec_z));
      prod[5]  <= P1W'($signed(quat.z) * $signed(vec.vec_x));
      prod[6]  <= P1W'($signed(quat.w) * $signed(vec.vec_z));
      prod[7]  <= P1W'($signed(quat.x) * $signed(vec.vec_y));
      prod[8]  <= P1W'($signed(quat.y) * $signed(vec.vec_x));
      prod[9]  <= P1W'($signed(quat.x) * $signed(vec.vec_x));
      prod[10] <= P1W'($signed(quat.y) * $signed(vec.vec_y));
      prod[11] <= P1W'($signed(quat.z) * $signed(vec.vec_z));
    end
  end

  // Stage two: three-term sums, one per part of t
  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv_sum) begin
      t_valid <= prod_valid;
    end
    if (adv_sum && prod_valid) begin
      t.x <= TW'(prod[0]) - TW'(prod[1]) + TW'(prod[2]);
      t.y <= TW'(prod[3]) + TW'(prod[4]) - TW'(prod[5]);
      t.z <= TW'(prod[6]) - TW'(prod[7]) + TW'(prod[8]);
      t.w <= TW'(prod[9]) + TW'(prod[10]) + TW'(prod[11]);
    end
  end

endmodule

@@ hw/rtl/qvr_vec_mul.sv @@
`timescale 1ns / 1ps
// Two pipeline stages forming the vector part of t * q: products, then sums.
// Depends on qvr_pkg.
module qvr_vec_mul
  import qvr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  quat_t  quat,
  input  logic   t_valid,
  output logic   t_stall,
  input  tquat_t t,
  output logic   r_valid,
  input  logic   r_stall,
  output rsum_t  r
);

  logic                  prod_valid;
  logic signed [P2W-1:0] prod [12];
  logic                  adv_prod;
  logic                  adv_sum;

  // Advance a stage when it is empty or the next one moves
  assign adv_sum  = !r_valid || !r_stall;
  assign adv_prod = !prod_valid || adv_sum;
  assign t_stall  = !adv_prod;

  // Stage three: the twelve 33x16 products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv_prod) begin
      prod_valid <= t_valid;
    end
    if (adv_prod && t_valid) begin
      prod[0]  <= P2W'($signed(t.w) * $signed(quat.x));
      prod[1]  <= P2W'($signed(t.x) * $signed(quat.w));
      prod[2]  <= P2W'($signed(t.y) * $signed(quat.z));
      prod[3]  <= P2W'($signed(t.z) * $signed(quat.y));
      prod[4]  <= P2W'($signed(t.w) * $signed(quat.y));
      prod[5]  <= P2W'($signed(t.x) * $signed(quat.z));
      prod[6]  <= P2W'($signed(t.y) * $signed(quat.w));
      prod[7]  <= P2W'($signed(t.z) * $signed(quat.x));
      prod[8]  <= P2W'($signed(t.w) * $signed(quat.z));
      prod[9]  <= P2W'($signed(t.x) * $signed(quat.y));
      prod[10] <= P2W'($signed(t.y) * $signed(quat.x));
      prod[11] <= P2W'($signed(t.z) * $signed(quat.w));
    end
  end

  // Stage four: four-term sums, one per output axis
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv_sum) begin
      r_valid <= prod_valid;
    end
    if (adv_sum && prod_valid) begin
      r.x <= RW'(prod[0]) + RW'(prod[1]) + RW'(prod[2]) - RW'(prod[3]);
      r.y <= RW'(prod[4]) - RW'(prod[5]) + RW'(prod[6]) + RW'(prod[7]);
      r.z <= RW'(prod[8]) + RW'(prod[9]) - RW'(prod[10]) + RW'(prod[11]);
    end
  end

endmodule

@@ hw/rtl/qvr_round_sat.sv @@
`timescale 1ns / 1ps
// Output stage: round each sum to nearest (ties upward), saturate to 16 bits.
// Depends on qvr_pkg.
module qvr_round_sat
  import qvr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  r_valid,
  output logic  r_stall,
  input  rsum_t r,
  output logic  rot_valid,
  input  logic  rot_stall,
  output rot_t  rot
);

  localparam int RDW = RW + 1 - FRAC_TOTAL;
  localparam logic signed [RW:0]    RND_HALF = (RW + 1)'(1) << (FRAC_TOTAL - 1);
  localparam logic signed [RDW-1:0] SAT_HI   = RDW'(32'sd32767);
  localparam logic signed [RDW-1:0] SAT_LO   = RDW'(-32'sd32768);

  logic                 adv;
  logic                 clip_x;
  logic                 clip_y;
  logic                 clip_z;
  logic signed [VW-1:0] sat_x;
  logic signed [VW-1:0] sat_y;
  logic signed [VW-1:0] sat_z;

  // Add half, floor by dropping the fraction, then clamp
  function automatic logic [VW:0] round_sat(input logic signed [RW-1:0] s);
    logic signed [RW:0]    biased;
    logic signed [RDW-1:0] whole;
    logic [VW:0]           res;
    biased = (RW + 1)'(s) + RND_HALF;
    whole  = $signed(biased[RW:FRAC_TOTAL]);
    if (whole > SAT_HI) begin
      res = {1'b1, SAT_HI[VW-1:0]};
    end else if (whole < SAT_LO) begin
      res = {1'b1, SAT_LO[VW-1:0]};
    end else begin
      res = {1'b0, whole[VW-1:0]};
    end
    return res;
  endfunction

  assign {clip_x, sat_x} = round_sat(r.x);
  assign {clip_y, sat_y} = round_sat(r.y);
  assign {clip_z, sat_z} = round_sat(r.z);

  assign adv     = !rot_valid || !rot_stall;
  assign r_stall = !adv;

  // Stage five: output register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
    end else if (adv) begin
      rot_valid <= r_valid;
    end
    if (adv && r_valid) begin
      rot.rot_x   <= sat_x;
      rot.rot_y   <= sat_y;
      rot.rot_z   <= sat_z;
      rot.clipped <= clip_x | clip_y | clip_z;
    end
  end

endmodule

@@ hw/rtl/quaternion_vector_rotate_unit.sv @@
`timescale 1ns / 1ps
// Rotates each 3-D vector by the configured quaternion q as conj(q)*(v,0)*q,
// rounding each part to nearest and saturating to 16 bits (clipped is set when
// any part saturated). The block takes one vector per cycle unless the output
// stalls, through a five-stage pipeline: products, sums, products, sums,
// round and saturate. A stall on the output backs up stage by stage, so empty
// stages still fill. q is not normalised. Write q only while no vector is in
// flight. Depends on qvr_pkg and the qvr_* stage modules.
module quaternion_vector_rotate_unit
  import qvr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  vec_valid,
  output logic                  vec_stall,
  input  vec_t                  vec,
  output logic                  rot_valid,
  input  logic                  rot_stall,
  output rot_t                  rot
);

  quat_t  quat;
  logic   t_valid;
  logic   t_stall;
  tquat_t t;
  logic   r_valid;
  logic   r_stall;
  rsum_t  r;

  // Hold the quaternion; reset gives the identity rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      quat.x <= '0;
      quat.y <= '0;
      quat.z <= '0;
      quat.w <= QUAT_W_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_QUAT_X: quat.x <= $signed(cfg_data);
        REG_QUAT_Y: quat.y <= $signed(cfg_data);
        REG_QUAT_Z: quat.z <= $signed(cfg_data);
        REG_QUAT_W: quat.w <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  qvr_conj_mul u_conj_mul (
    .clk       (clk),
    .rst       (rst),
    .quat      (quat),
    .vec_valid (vec_valid),
    .vec_stall (vec_stall),
    .vec       (vec),
    .t_valid   (t_valid),
    .t_stall   (t_stall),
    .t         (t)
  );

  qvr_vec_mul u_vec_mul (
    .clk     (clk),
    .rst     (rst),
    .quat    (quat),
    .t_valid (t_valid),
    .t_stall (t_stall),
    .t       (t),
    .r_valid (r_valid),
    .r_stall (r_stall),
    .r       (r)
  );

  qvr_round_sat u_round_sat (
    .clk       (clk),
    .rst       (rst),
    .r_valid   (r_valid),
    .r_stall   (r_stall),
    .r         (r),
    .rot_valid (rot_valid),
    .rot_stall (rot_stall),
    .rot       (rot)
  );

`ifndef NO_ASSERTIONS
  // Reset must leave the identity scalar part in place
  a_reset_identity: assert property (@(posedge clk) rst |=> quat.w == QUAT_W_RESET)
    else $error("quat_w not at identity after reset");

  // Input backs up only when the output itself is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    vec_stall |-> (rot_valid && rot_stall && r_valid && t_valid))
    else $error("input stalled with a bubble in the pipeline");

  // A clipped result has at least one component at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (rot_valid && rot.clipped) |->
      (rot.rot_x == 16'sh7fff || rot.rot_x == -16'sh8000 ||
       rot.rot_y == 16'sh7fff || rot.rot_y == -16'sh8000 ||
       rot.rot_z == 16'sh7fff || rot.rot_z == -16'sh8000))
    else $error("clipped set without a saturated component");
`endif

endmodule
